/* sv/yhpid_pkg.sv */
// ----------------------------------------------------------------------------
// Yaw-hold PID package
// Shared types, register indexes and constants for the yaw-hold PID core.
// ----------------------------------------------------------------------------
package yhpid_pkg;

	localparam int PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;

	// Datapath operations, one per microcode step.
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_CHECK,
		OP_MUL_ED,
		OP_DIV1_SET,
		OP_DIV_STEP,
		OP_INTEG,
		OP_MUL_PE,
		OP_MUL_II,
		OP_ADD_PI,
		OP_MUL_AD,
		OP_MUL_DE,
		OP_MUL_K,
		OP_SUM_NUM,
		OP_DIV2_SET,
		OP_FINISH,
		OP_ZERO,
		OP_RECIP
	} op_t;

	// Jump conditions of the sequencer.
	typedef enum logic [2:0] {
		COND_NONE,
		COND_NO_INPUT,
		COND_DEAD,
		COND_DIV_BUSY,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
		logic  done;
	} uword_t;

	typedef struct packed {
		logic no_input;
		logic dead;
		logic div_busy;
		logic out_busy;
	} status_t;

	localparam pc_t STEP_IDLE = 5'd0;
	localparam pc_t STEP_LAST = 5'd16;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND     = 3'd4;

endpackage

/* sv/yaw_hold_pid_controller_core.sv */
// ----------------------------------------------------------------------------
// Yaw-hold PID controller core
// PID heading hold with a dead band and integral clamp, run by microcode.
// ----------------------------------------------------------------------------
// Each input transaction carries one control tick: the measured yaw in Q3.12
// radians and the milliseconds since the previous tick. The core answers
// every tick with exactly one output transaction: the forward speed register,
// the turn command clamped to plus or minus 1.0, and a flag that tells
// whether the PID step ran or the error sat inside the dead band.
// Both channels use valid and stall; a transaction completes on a clock edge
// with valid high and stall low. The core takes one tick at a time. A tick
// inside the dead band passes the check step and then the zero step, which
// writes its result. A correcting tick runs the multiply and add steps around
// the shared multiplier, the reciprocal multiply that divides by 1000 and the
// 13-step bit-serial divide by the elapsed time before the finish step
// writes its result.
// The next tick is accepted in the cycle after the result is written, so a
// result that the receiver stalls does not hold up the following tick's
// arithmetic; only the final write step waits for the output register to
// drain. Configuration writes are taken at any time through cfg_valid and
// cfg_ready (always ready) and must be issued only while the core is idle.
// Writing any gain clears the integral, the last error and the elapsed time.
// Reset loads the default gains, clears the state and empties the output.
// ----------------------------------------------------------------------------
module yaw_hold_pid_controller_core
	import yhpid_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [14:0]   yaw_angle,
	input  logic        [15:0]   tick_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [15:0]   linear_cmd,
	output logic signed [13:0]   angular_cmd,
	output logic                 correcting,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic        [15:0]   cfg_data
);

	pc_t     pc;
	uword_t  uw;
	status_t st;

	// The program sits on its first step while waiting for a tick, so the
	// input side is open exactly there.
	assign in_stall  = (pc != STEP_IDLE);
	assign cfg_ready = 1'b1;

	yhpid_ucode_rom u_rom (
		.pc (pc),
		.uw (uw)
	);

	yhpid_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.uw     (uw),
		.st     (st),
		.pc     (pc)
	);

	yhpid_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (uw.op),
		.st          (st),
		.in_valid    (in_valid),
		.yaw_angle   (yaw_angle),
		.tick_ms     (tick_ms),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.linear_cmd  (linear_cmd),
		.angular_cmd (angular_cmd),
		.correcting  (correcting)
	);

`ifndef ASSERT_OFF
	// The input side opens only while no result is being written.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (uw.op == OP_LOAD))
		else $error("tick accepted outside the load step");
`endif

endmodule

/* sv/yhpid_ucode_rom.sv */
// ----------------------------------------------------------------------------
// Yaw-hold PID microcode ROM
// Control program of the core: one control word per step.
// ----------------------------------------------------------------------------
module yhpid_ucode_rom
	import yhpid_pkg::*;
(
	input  pc_t    pc,
	output uword_t uw
);

	localparam pc_t S_LOAD     = 5'd0;
	localparam pc_t S_CHECK    = 5'd1;
	localparam pc_t S_MUL_ED   = 5'd2;
	localparam pc_t S_DIV1_SET = 5'd3;
	localparam pc_t S_DIV1     = 5'd4;
	localparam pc_t S_INTEG    = 5'd5;
	localparam pc_t S_MUL_PE   = 5'd6;
	localparam pc_t S_MUL_II   = 5'd7;
	localparam pc_t S_ADD_PI   = 5'd8;
	localparam pc_t S_MUL_AD   = 5'd9;
	localparam pc_t S_MUL_DE   = 5'd10;
	localparam pc_t S_MUL_K    = 5'd11;
	localparam pc_t S_SUM_NUM  = 5'd12;
	localparam pc_t S_DIV2_SET = 5'd13;
	localparam pc_t S_DIV2     = 5'd14;
	localparam pc_t S_FINISH   = 5'd15;
	localparam pc_t S_ZERO     = 5'd16;

	always_comb begin
		unique case (pc)
			S_LOAD:     uw = '{OP_LOAD,     COND_NO_INPUT, S_LOAD,    1'b0};
			S_CHECK:    uw = '{OP_CHECK,    COND_DEAD,     S_ZERO,    1'b0};
			S_MUL_ED:   uw = '{OP_MUL_ED,   COND_NONE,     STEP_IDLE, 1'b0};
			S_DIV1_SET: uw = '{OP_DIV1_SET, COND_NONE,     STEP_IDLE, 1'b0};
			S_DIV1:     uw = '{OP_RECIP,    COND_NONE,     STEP_IDLE, 1'b0};
			S_INTEG:    uw = '{OP_INTEG,    COND_NONE,     STEP_IDLE, 1'b0};
			S_MUL_PE:   uw = '{OP_MUL_PE,   COND_NONE,     STEP_IDLE, 1'b0};
			S_MUL_II:   uw = '{OP_MUL_II,   COND_NONE,     STEP_IDLE, 1'b0};
			S_ADD_PI:   uw = '{OP_ADD_PI,   COND_NONE,     STEP_IDLE, 1'b0};
			S_MUL_AD:   uw = '{OP_MUL_AD,   COND_NONE,     STEP_IDLE, 1'b0};
			S_MUL_DE:   uw = '{OP_MUL_DE,   COND_NONE,     STEP_IDLE, 1'b0};
			S_MUL_K:    uw = '{OP_MUL_K,    COND_NONE,     STEP_IDLE, 1'b0};
			S_SUM_NUM:  uw = '{OP_SUM_NUM,  COND_NONE,     STEP_IDLE, 1'b0};
			S_DIV2_SET: uw = '{OP_DIV2_SET, COND_NONE,     STEP_IDLE, 1'b0};
			S_DIV2:     uw = '{OP_DIV_STEP, COND_DIV_BUSY, S_DIV2,    1'b0};
			S_FINISH:   uw = '{OP_FINISH,   COND_OUT_BUSY, S_FINISH,  1'b1};
			S_ZERO:     uw = '{OP_ZERO,     COND_OUT_BUSY, S_ZERO,    1'b1};
			default:    uw = '{OP_NOP,      COND_NONE,     STEP_IDLE, 1'b1};
		endcase
	end

endmodule

/* sv/yhpid_sequencer.sv */
// ----------------------------------------------------------------------------
// Yaw-hold PID sequencer
// Step counter with conditional jumps, driven by the microcode ROM.
// ----------------------------------------------------------------------------
module yhpid_sequencer
	import yhpid_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  uword_t  uw,
	input  status_t st,
	output pc_t     pc
);

	pc_t  pc_q;
	pc_t  pc_next;
	logic cond_hit;

	always_comb begin
		unique case (uw.cond)
			COND_NONE:     cond_hit = 1'b0;
			COND_NO_INPUT: cond_hit = st.no_input;
			COND_DEAD:     cond_hit = st.dead;
			COND_DIV_BUSY: cond_hit = st.div_busy;
			COND_OUT_BUSY: cond_hit = st.out_busy;
			default:       cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		priority if (cond_hit) begin
			pc_next = uw.target;
		end else if (uw.done) begin
			pc_next = STEP_IDLE;
		end else begin
			pc_next = pc_q + pc_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	assign pc = pc_q;

`ifndef ASSERT_OFF
	// The program counter never leaves the program.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= STEP_LAST)
		else $error("sequencer left the program");
	// A finished item always returns to the idle step.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.done && !cond_hit) |=> (pc_q == STEP_IDLE))
		else $error("sequencer did not return to idle");
`endif

endmodule

/* sv/yhpid_datapath.sv */
// ----------------------------------------------------------------------------
// Yaw-hold PID datapath
// Registers, shared multiplier, bit-serial divider and output register.
// ----------------------------------------------------------------------------
module yhpid_datapath
	import yhpid_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  op_t                   op,
	output status_t               st,
	input  logic                  in_valid,
	input  logic signed [14:0]    yaw_angle,
	input  logic        [15:0]    tick_ms,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic        [15:0]    cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [15:0]    linear_cmd,
	output logic signed [13:0]    angular_cmd,
	output logic                  correcting
);

	localparam logic signed [14:0] YAW_MIN = 15'sh4000;
	localparam logic signed [14:0] ERR_MAX = 15'sd16383;
	localparam logic signed [13:0] ONE_Q12 = 14'sd4096;
	localparam logic signed [13:0] MONE_Q12 = -14'sd4096;
	localparam logic [15:0] DEFAULT_DT = 16'd100;
	localparam logic [31:0] DIV1_HALF = 32'd500;
	localparam logic [31:0] DIV1_SAT = 32'd8193000;
	localparam logic [13:0] DIV1_SATQ = 14'd8193;
	localparam logic [13:0] DIV2_SATQ = 14'd4097;
	localparam logic [3:0] DIV2_TOP = 4'd12;
	// Reciprocal of 1000 scaled by 2^33, rounded up. Exact for every dividend
	// below 2^23, which covers every value that is not preset to clamp.
	localparam logic [23:0] RECIP_1000 = 24'd8589935;

	// Configuration and controller state.
	logic        [15:0] prop_gain_q, integ_gain_q, deriv_gain_q;
	logic signed [15:0] forward_speed_q;
	logic        [11:0] dead_band_q;
	logic signed [13:0] isum_q;
	logic signed [14:0] last_err_q;
	logic        [15:0] ms_q;

	// Working registers.
	logic signed [14:0] err_q;
	logic        [15:0] dt_q;
	logic signed [49:0] prod_q, acc_q;
	logic        [30:0] rem_q;
	logic        [15:0] den_q;
	logic        [13:0] quo_q;
	logic        [3:0]  cnt_q;
	logic               neg_q;

	// Output register.
	logic               out_valid_q, correcting_q;
	logic signed [15:0] linear_q;
	logic signed [13:0] angular_q;

	logic signed [14:0] err_in;
	logic        [16:0] ms_sum;
	logic        [15:0] ms_sat;
	logic        [14:0] err_abs;
	logic               dead;
	logic signed [15:0] ediff;
	logic signed [31:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [49:0] prod_c;
	logic        [49:0] prod_mag, acc_mag;
	logic        [31:0] x1;
	logic               sat1;
	logic        [46:0] recip_prod;
	logic        [50:0] x2_full;
	logic        [42:0] x2;
	logic               sat2;
	logic        [30:0] shifted;
	logic signed [15:0] q1, isum_sum;
	logic signed [13:0] isum_next;
	logic        [12:0] fin_mag;
	logic signed [13:0] fin_val;
	logic               out_busy, emit;

	assign err_in = (yaw_angle == YAW_MIN) ? ERR_MAX : -yaw_angle;
	assign ms_sum = {1'b0, ms_q} + {1'b0, tick_ms};
	assign ms_sat = ms_sum[16] ? 16'hFFFF : ms_sum[15:0];

	assign err_abs = err_q[14] ? 15'(-err_q) : 15'(err_q);
	assign dead = {3'b000, dead_band_q} >= err_abs;
	assign ediff = {err_q[14], err_q} - {last_err_q[14], last_err_q};

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (op)
			OP_MUL_ED: begin
				mul_a = {{17{err_q[14]}}, err_q};
				mul_b = {2'b00, dt_q};
			end
			OP_MUL_PE: begin
				mul_a = {{17{err_q[14]}}, err_q};
				mul_b = {2'b00, prop_gain_q};
			end
			OP_MUL_II: begin
				mul_a = {{18{isum_q[13]}}, isum_q};
				mul_b = {2'b00, integ_gain_q};
			end
			OP_MUL_AD: begin
				mul_a = acc_q[31:0];
				mul_b = {2'b00, dt_q};
			end
			OP_MUL_DE: begin
				mul_a = {{16{ediff[15]}}, ediff};
				mul_b = {2'b00, deriv_gain_q};
			end
			OP_MUL_K: begin
				mul_a = prod_q[31:0];
				mul_b = 18'sd1000;
			end
			OP_SUM_NUM: begin
				mul_a = {16'b0, dt_q};
				mul_b = 18'sd4097;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_c = mul_a * mul_b;

	// Divider setup. A quotient that would clamp anyway is preset so the
	// divide loop leaves it unchanged.
	assign prod_mag = prod_q[49] ? 50'(-prod_q) : 50'(prod_q);
	assign x1 = {1'b0, prod_mag[30:0]} + DIV1_HALF;
	assign sat1 = x1 >= DIV1_SAT;

	// The division by 1000 is a multiply by the scaled reciprocal.
	assign recip_prod = rem_q[22:0] * RECIP_1000;

	assign acc_mag = acc_q[49] ? 50'(-acc_q) : 50'(acc_q);
	assign x2_full = {1'b0, acc_mag} + {28'b0, dt_q, 7'b0};
	assign x2 = x2_full[50:8];
	assign sat2 = {7'b0, x2} >= $unsigned(prod_q);

	assign shifted = {15'b0, den_q} << cnt_q;

	assign q1 = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
	assign isum_sum = {{2{isum_q[13]}}, isum_q} + q1;
	assign isum_next = (isum_sum > 16'sd4096) ? ONE_Q12 :
		((isum_sum < -16'sd4096) ? MONE_Q12 : isum_sum[13:0]);

	assign fin_mag = (quo_q > 14'd4096) ? 13'd4096 : quo_q[12:0];
	assign fin_val = neg_q ? -$signed({1'b0, fin_mag}) : $signed({1'b0, fin_mag});

	assign out_busy = out_valid_q && out_stall;
	assign emit = ((op == OP_FINISH) || (op == OP_ZERO)) && !out_busy;

	assign st = '{no_input: !in_valid, dead: dead, div_busy: (cnt_q != 4'd0),
		out_busy: out_busy};

	// Control, configuration, controller state and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= 16'd512;
			integ_gain_q    <= 16'd26;
			deriv_gain_q    <= 16'd128;
			forward_speed_q <= 16'sd2048;
			dead_band_q     <= 12'd41;
			isum_q          <= '0;
			last_err_q      <= '0;
			ms_q            <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (op)
				OP_LOAD: begin
					if (in_valid) begin
						ms_q <= ms_sat;
					end
				end
				OP_INTEG: begin
					isum_q <= isum_next;
				end
				OP_FINISH: begin
					if (emit) begin
						last_err_q  <= err_q;
						ms_q        <= '0;
						out_valid_q <= 1'b1;
					end
				end
				OP_ZERO: begin
					if (emit) begin
						isum_q      <= '0;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_PROP_GAIN: begin
						prop_gain_q <= cfg_data;
						isum_q      <= '0;
						last_err_q  <= '0;
						ms_q        <= '0;
					end
					REG_INTEG_GAIN: begin
						integ_gain_q <= cfg_data;
						isum_q       <= '0;
						last_err_q   <= '0;
						ms_q         <= '0;
					end
					REG_DERIV_GAIN: begin
						deriv_gain_q <= cfg_data;
						isum_q       <= '0;
						last_err_q   <= '0;
						ms_q         <= '0;
					end
					REG_FORWARD_SPEED: forward_speed_q <= cfg_data;
					REG_DEAD_BAND:     dead_band_q <= cfg_data[11:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Working registers and output payload.
	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				if (in_valid) begin
					err_q <= err_in;
				end
				cnt_q <= '0;
			end
			OP_CHECK: begin
				dt_q <= (ms_q == 16'd0) ? DEFAULT_DT : ms_q;
			end
			OP_MUL_ED, OP_MUL_PE, OP_MUL_AD, OP_MUL_K: begin
				prod_q <= prod_c;
			end
			OP_MUL_II, OP_MUL_DE: begin
				acc_q  <= prod_q;
				prod_q <= prod_c;
			end
			OP_ADD_PI: begin
				acc_q <= acc_q + prod_q;
			end
			OP_SUM_NUM: begin
				acc_q  <= acc_q + prod_q;
				prod_q <= prod_c;
			end
			OP_DIV1_SET: begin
				neg_q <= prod_q[49];
				rem_q <= sat1 ? 31'd0 : x1[30:0];
				quo_q <= sat1 ? DIV1_SATQ : 14'd0;
			end
			OP_RECIP: begin
				// A preset clamp value comes with a cleared dividend, so the
				// OR keeps it; otherwise the quotient starts from zero.
				quo_q <= quo_q | recip_prod[46:33];
			end
			OP_DIV2_SET: begin
				neg_q <= acc_q[49];
				den_q <= dt_q;
				cnt_q <= DIV2_TOP;
				rem_q <= sat2 ? 31'd0 : x2[30:0];
				quo_q <= sat2 ? DIV2_SATQ : 14'd0;
			end
			OP_DIV_STEP: begin
				if (rem_q >= shifted) begin
					rem_q <= rem_q - shifted;
					quo_q[cnt_q] <= 1'b1;
				end
				if (cnt_q != 4'd0) begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
			OP_FINISH: begin
				if (emit) begin
					linear_q     <= forward_speed_q;
					angular_q    <= fin_val;
					correcting_q <= 1'b1;
				end
			end
			OP_ZERO: begin
				if (emit) begin
					linear_q     <= forward_speed_q;
					angular_q    <= '0;
					correcting_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign linear_cmd  = linear_q;
	assign angular_cmd = angular_q;
	assign correcting  = correcting_q;

`ifndef ASSERT_OFF
	// The integral never leaves its clamp.
	a_isum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(isum_q >= MONE_Q12) && (isum_q <= ONE_Q12))
		else $error("integral outside its clamp");
	// A result shown to the receiver stays within plus or minus 1.0.
	a_angular_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((angular_q >= MONE_Q12) && (angular_q <= ONE_Q12)))
		else $error("turn command outside its clamp");
	// Inside the dead band the turn command is zero.
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !correcting_q) |-> (angular_q == 14'sd0))
		else $error("nonzero turn command without correction");
`endif

endmodule

/* tb/yaw_hold_pid_controller_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Yaw-hold PID command checker
// Watches the tick, result and register channels of the core. It predicts
// every turn command and compares each result against the oldest prediction.
// ----------------------------------------------------------------------------
module yaw_hold_pid_controller_checker
	import yhpid_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic signed [14:0]   yaw_angle,
	input  logic        [15:0]   tick_ms,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic signed [15:0]   linear_cmd,
	input  logic signed [13:0]   angular_cmd,
	input  logic                 correcting,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic        [15:0]   cfg_data,
	output int                   pending_cnt,
	output int                   mismatch_count
);

	localparam longint UNIT_Q12        = 4096;
	localparam longint ERR_MAX         = 16383;
	localparam longint MS_CEIL         = 65535;
	localparam longint DEFAULT_SPAN_MS = 100;
	localparam int     REPORT_LIMIT    = 10;

	typedef struct {
		logic signed [15:0] linear;
		logic signed [13:0] angular;
		logic               corr;
	} motion_cmd_t;

	motion_cmd_t expected_cmds[$];

	// Register copies.
	logic        [15:0] kp, ki, kd;
	logic signed [15:0] fwd_speed;
	logic        [11:0] band;

	// Loop state.
	longint integ_sum, prev_err, elapsed_ms;

	int results_seen;

	// Nearest integer, ties away from zero; den is always positive.
	function automatic longint round_div(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint limit_unit(longint v);
		if (v < -UNIT_Q12)
			return -UNIT_Q12;
		if (v > UNIT_Q12)
			return UNIT_Q12;
		return v;
	endfunction

	// One control tick: updates the loop state and returns the command.
	function automatic motion_cmd_t heading_step(logic signed [14:0] yaw, logic [15:0] ms);
		motion_cmd_t res;
		longint err, mag, span, num, acc;
		err = -longint'(yaw);
		if (err > ERR_MAX)
			err = ERR_MAX;
		acc = elapsed_ms + longint'(ms);
		elapsed_ms = (acc > MS_CEIL) ? MS_CEIL : acc;
		mag = (err < 0) ? -err : err;
		res.linear = fwd_speed;
		if (mag <= longint'(band)) begin
			integ_sum = 0;
			res.angular = '0;
			res.corr = 1'b0;
		end else begin
			span = (elapsed_ms == 0) ? DEFAULT_SPAN_MS : elapsed_ms;
			integ_sum = limit_unit(integ_sum + round_div(err * span, 1000));
			num = (longint'(kp) * err + longint'(ki) * integ_sum) * span
				+ longint'(kd) * (err - prev_err) * 1000;
			res.angular = 14'(limit_unit(round_div(num, 256 * span)));
			res.corr = 1'b1;
			prev_err = err;
			elapsed_ms = 0;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		motion_cmd_t want;
		if (!arst_n) begin
			kp = 16'd512;
			ki = 16'd26;
			kd = 16'd128;
			fwd_speed = 16'sd2048;
			band = 12'd41;
			integ_sum = 0;
			prev_err = 0;
			elapsed_ms = 0;
			expected_cmds.delete();
			results_seen = 0;
			mismatch_count = 0;
			pending_cnt <= 0;
		end else begin
			// Register writes come only while the core is idle, so they apply
			// before any tick taken at a later edge.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROP_GAIN:     kp = cfg_data;
					REG_INTEG_GAIN:    ki = cfg_data;
					REG_DERIV_GAIN:    kd = cfg_data;
					REG_FORWARD_SPEED: fwd_speed = cfg_data;
					REG_DEAD_BAND:     band = cfg_data[11:0];
					default: ;
				endcase
				if (cfg_index == REG_PROP_GAIN || cfg_index == REG_INTEG_GAIN
						|| cfg_index == REG_DERIV_GAIN) begin
					integ_sum = 0;
					prev_err = 0;
					elapsed_ms = 0;
				end
			end
			if (in_valid && !in_stall)
				expected_cmds.push_back(heading_step(yaw_angle, tick_ms));
			if (out_valid && !out_stall) begin
				if (expected_cmds.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("result %0d arrived with nothing expected: linear %0d angular %0d correcting %0b",
							results_seen, linear_cmd, angular_cmd, correcting);
				end else begin
					want = expected_cmds.pop_front();
					if (want.linear !== linear_cmd || want.angular !== angular_cmd
							|| want.corr !== correcting) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("result %0d: expected linear %0d angular %0d correcting %0b, got linear %0d angular %0d correcting %0b",
								results_seen, want.linear, want.angular, want.corr,
								linear_cmd, angular_cmd, correcting);
					end
				end
				results_seen++;
			end
			pending_cnt <= expected_cmds.size();
		end
	end

endmodule

/* tb/yaw_hold_pid_controller_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Yaw-hold PID controller core test
// Drives control ticks and register writes into the core while a checker
// predicts and compares every command; the top gives the final verdict.
// ----------------------------------------------------------------------------
// The run opens with a short directed sequence under the reset gains: zero
// error, both edges of the dead band, the most negative yaw that has to
// saturate, ticks with no elapsed time, and elapsed time that runs into its
// ceiling. After that come several phases, each started from an idle core
// with a new register setting (all gains at their maximum, all at zero, the
// reset values, writes that must not clear the loop state, a write to an
// unused index, and random settings), followed by random ticks.
// The sender works in bursts with random gaps, the receiver switches at
// random between stall patterns, and some phases run with no sender gaps
// at all.
// ----------------------------------------------------------------------------
module yaw_hold_pid_controller_core_test;
	import yhpid_pkg::*;

	// An index that maps to no register; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	localparam int  PHASES           = 7;
	localparam int  RANDOM_PER_PHASE = 190;
	// Extra wait after the last result, before the verdict.
	localparam int  SETTLE_CYCLES    = 64;
	localparam time RUN_LIMIT        = 8ms;

	localparam logic signed [14:0] YAW_MOST_NEG = 15'sh4000;
	localparam logic signed [14:0] YAW_MOST_POS = 15'sd16383;
	localparam logic signed [14:0] YAW_PI       = 15'sd12868;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic signed [14:0]   yaw_angle   = '0;
	logic        [15:0]   tick_ms     = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic signed [15:0]   linear_cmd;
	logic signed [13:0]   angular_cmd;
	logic                 correcting;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = REG_PROP_GAIN;
	logic        [15:0]   cfg_data    = '0;

	int pending_cnt;
	int mismatch_count;

	// Sender pacing: transactions left in the current burst, and whether
	// gaps are allowed between bursts in this phase.
	int burst_left = 0;
	bit gaps_on    = 1'b1;

	// The top keeps its own copy of the dead band to aim ticks at its edges.
	logic [11:0] dead_band_now = 12'd41;

	stall_mode_t stall_mode;
	logic [15:0] stall_tick;

	yaw_hold_pid_controller_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.yaw_angle   (yaw_angle),
		.tick_ms     (tick_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.linear_cmd  (linear_cmd),
		.angular_cmd (angular_cmd),
		.correcting  (correcting),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	yaw_hold_pid_controller_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.yaw_angle      (yaw_angle),
		.tick_ms        (tick_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.linear_cmd     (linear_cmd),
		.angular_cmd    (angular_cmd),
		.correcting     (correcting),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pending_cnt    (pending_cnt),
		.mismatch_count (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver back-pressure. Each low-byte wrap draws a new mode, so long
	// stretches with no stall alternate with light, heavy and periodic stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_tick <= '0;
			stall_mode <= STALL_NONE;
		end else begin
			stall_tick <= stall_tick + 16'd1;
			if (stall_tick[7:0] == 8'd0)
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
				default:     out_stall <= (stall_tick[4:2] == 3'b011);
			endcase
		end
	end

	// Offers one tick and returns at the edge where the transaction completes.
	// A new burst may start with a random gap; valid stays high inside a burst.
	task automatic send_tick(input logic signed [14:0] yaw, input logic [15:0] ms);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = gaps_on ? $urandom_range(0, 8) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		yaw_angle <= yaw;
		tick_ms <= ms;
		do @(posedge clk); while (in_stall);
	endtask

	// Stops sending and waits until the checker holds no expected result.
	// The first edge lets the checker count a tick taken at this very edge.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0) @(posedge clk);
	endtask

	// Leaves cfg_valid high so that back-to-back writes never lower and
	// raise it in one step; the caller lowers it after the last write.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_DEAD_BAND)
			dead_band_now = data[11:0];
	endtask

	initial begin
		logic signed [14:0] yaw_pick;
		logic        [15:0] ms_pick;
		int                 near;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks under the reset register values.
		send_tick(15'sd0, 16'd0);           // no error at all, nothing elapsed
		send_tick(YAW_MOST_NEG, 16'd0);     // error saturates; no time, so 100 ms
		send_tick(YAW_MOST_NEG, 16'd0);     // same error again: no derivative kick
		send_tick(YAW_MOST_POS, 16'd0);     // largest positive yaw, full swing
		send_tick(15'sd41, 16'd25);         // exactly on the dead band: no turn
		send_tick(-15'sd41, 16'd25);
		send_tick(15'sd42, 16'd25);         // one step outside the dead band
		send_tick(-15'sd42, 16'd25);
		send_tick(YAW_PI, 16'd100);
		send_tick(-YAW_PI, 16'd100);
		send_tick(15'sd0, 16'd65535);       // idle ticks pile up elapsed time
		send_tick(15'sd0, 16'd65535);       // which now sits at its ceiling
		send_tick(15'sd30, 16'd1);
		send_tick(-15'sd3000, 16'd1);       // huge span: integral hits its clamp
		send_tick(15'sd3000, 16'd100);
		send_tick(-15'sd1, 16'd65535);
		send_tick(15'sd2, 16'd0);
		send_tick(15'sd2000, 16'd0);        // correction over a saturated span

		for (int phase = 0; phase < PHASES; phase++) begin
			// Registers change only with the core idle and every result in.
			drain_results();
			case (phase)
				0: begin
					write_register(REG_PROP_GAIN, 16'hFFFF);
					write_register(REG_INTEG_GAIN, 16'hFFFF);
					write_register(REG_DERIV_GAIN, 16'hFFFF);
					write_register(REG_FORWARD_SPEED, 16'h7FFF);
					write_register(REG_DEAD_BAND, 16'h0FFF);
					write_register(REG_SPARE, 16'h0000);
				end
				1: begin
					write_register(REG_PROP_GAIN, 16'h0000);
					write_register(REG_INTEG_GAIN, 16'h0000);
					write_register(REG_DERIV_GAIN, 16'h0000);
					write_register(REG_FORWARD_SPEED, 16'h8000);
					write_register(REG_DEAD_BAND, 16'h0000);
				end
				2: begin
					write_register(REG_PROP_GAIN, 16'd512);
					write_register(REG_INTEG_GAIN, 16'd26);
					write_register(REG_DERIV_GAIN, 16'd128);
					write_register(REG_FORWARD_SPEED, 16'd2048);
					write_register(REG_DEAD_BAND, 16'd41);
				end
				3: begin
					// The loop state from the previous phase must survive these.
					write_register(REG_FORWARD_SPEED, 16'($urandom));
					write_register(REG_DEAD_BAND, 16'($urandom_range(0, 120)));
					write_register(REG_SPARE, 16'hFFFF);
				end
				default: begin
					write_register(REG_PROP_GAIN,
						($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048)));
					write_register(REG_INTEG_GAIN,
						($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512)));
					write_register(REG_DERIV_GAIN,
						($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024)));
					write_register(REG_FORWARD_SPEED, 16'($urandom));
					write_register(REG_DEAD_BAND,
						($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 4095))
							: 16'($urandom_range(0, 200)));
				end
			endcase
			cfg_valid <= 1'b0;
			gaps_on = (phase % 3 != 1);

			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// Most yaw values sit in the physical range or hug the dead
				// band edges; some use the whole field or its extremes.
				case ($urandom_range(0, 9))
					0: yaw_pick = 15'($urandom);
					1, 2: begin
						near = int'(dead_band_now) + int'($urandom_range(0, 6)) - 3;
						if (near < 0)
							near = 0;
						yaw_pick = $urandom_range(0, 1) ? 15'(near) : 15'(-near);
					end
					8: begin
						case ($urandom_range(0, 3))
							0: yaw_pick = YAW_MOST_NEG;
							1: yaw_pick = YAW_MOST_POS;
							2: yaw_pick = -YAW_PI;
							default: yaw_pick = YAW_PI;
						endcase
					end
					9: yaw_pick = 15'(int'($urandom_range(0, 400)) - 200);
					default: yaw_pick = 15'(int'($urandom_range(0, 2 * YAW_PI)) - YAW_PI);
				endcase
				// Ticks are mostly near the nominal 100 ms period.
				case ($urandom_range(0, 9))
					0: ms_pick = 16'd0;
					1: ms_pick = 16'($urandom);
					2: ms_pick = 16'hFFFF;
					3: ms_pick = 16'($urandom_range(0, 10));
					default: ms_pick = 16'($urandom_range(80, 120));
				endcase
				send_tick(yaw_pick, ms_pick);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// A hung handshake or a result that never arrives ends here.
	initial begin
		#(RUN_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

endmodule
